// ----- hdl/flht_pkg.sv -----
package flht_pkg;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned RefWidth = 32;

  localparam int unsigned SlotWidth  = $clog2(Capacity);
  localparam int unsigned MarkWidth  = $clog2(Capacity + 1);
  localparam int unsigned ReqWidth   = 2;
  localparam int unsigned ValueWidth = 32;

  localparam logic [ReqWidth-1:0] ReqInsert = 2'd0;
  localparam logic [ReqWidth-1:0] ReqGet    = 2'd1;
  localparam logic [ReqWidth-1:0] ReqFree   = 2'd2;

  localparam logic [MarkWidth-1:0] MarkFull = MarkWidth'(Capacity);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
  } flht_cmd_t;

endpackage

// ----- hdl/flht_ctrl.sv -----
module flht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  output flht_pkg::flht_cmd_t cmd_o
);
  import flht_pkg::*;

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          done_q <= 1'b0;
          if (start_i) begin
            state_q <= StExec;
            busy_q  <= 1'b1;
          end
        end
        StExec: begin
          state_q <= StIdle;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= StIdle;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  assign cmd_o.capture = start_i && !busy_q;
  assign cmd_o.exec    = (state_q == StExec);
  assign busy_o        = busy_q;
  assign done_o        = done_q;

`ifndef SYNTHESIS
  a_transfer_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o ##1 done_o)
    else $error("accepted request did not complete in two cycles");
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
`endif

endmodule

// ----- hdl/flht_datapath.sv -----
module flht_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  flht_pkg::flht_cmd_t                cmd_i,
  input  logic [flht_pkg::ReqWidth-1:0]      req_type_i,
  input  logic [flht_pkg::SlotWidth-1:0]     slot_index_i,
  input  logic [flht_pkg::ValueWidth-1:0]    ref_value_i,
  output logic [flht_pkg::SlotWidth-1:0]     slot_out_o,
  output logic [flht_pkg::ValueWidth-1:0]    value_out_o,
  output logic                               error_o
);
  import flht_pkg::*;

  logic [RefWidth-1:0]  value_mem [Capacity];
  logic [MarkWidth-1:0] link_mem  [Capacity];

  logic [MarkWidth-1:0] free_head_q, free_head_d;
  logic [MarkWidth-1:0] fresh_mark_q, fresh_mark_d;

  logic [ReqWidth-1:0]  req_q;
  logic [SlotWidth-1:0] idx_q;
  logic [RefWidth-1:0]  ref_q;
  logic [RefWidth-1:0]  val_rd_q;
  logic [MarkWidth-1:0] link_rd_q;

  logic [SlotWidth-1:0]  slot_out_q, slot_d;
  logic [ValueWidth-1:0] value_out_q, value_d;
  logic                  error_q, error_d;

  logic                 val_we, link_we;
  logic [SlotWidth-1:0] val_wa;
  logic [RefWidth-1:0]  val_wd;

  logic [MarkWidth-1:0] idx_ext;
  logic                 stack_empty, table_full, idx_live;

  // Capture the request and issue both memory reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q     <= req_type_i;
      idx_q     <= slot_index_i;
      ref_q     <= RefWidth'(ref_value_i);
      val_rd_q  <= value_mem[slot_index_i];
      link_rd_q <= link_mem[free_head_q[SlotWidth-1:0]];
    end
  end

  assign idx_ext     = MarkWidth'(idx_q);
  assign stack_empty = (free_head_q == fresh_mark_q);
  assign table_full  = (fresh_mark_q == MarkFull);
  assign idx_live    = (idx_ext < fresh_mark_q);

  always_comb begin
    free_head_d  = free_head_q;
    fresh_mark_d = fresh_mark_q;
    slot_d       = idx_q;
    value_d      = '0;
    error_d      = 1'b0;
    val_we       = 1'b0;
    val_wa       = idx_q;
    val_wd       = '0;
    link_we      = 1'b0;
    case (req_q)
      ReqInsert: begin
        val_wd = ref_q;
        if (stack_empty && table_full) begin
          slot_d  = '0;
          error_d = 1'b1;
        end else if (stack_empty) begin
          // Take the watermark slot and advance the mark.
          slot_d       = fresh_mark_q[SlotWidth-1:0];
          fresh_mark_d = fresh_mark_q + 1'b1;
          free_head_d  = fresh_mark_q + 1'b1;
          val_we       = 1'b1;
          val_wa       = fresh_mark_q[SlotWidth-1:0];
        end else begin
          // Pop the free stack.
          slot_d      = free_head_q[SlotWidth-1:0];
          free_head_d = link_rd_q;
          val_we      = 1'b1;
          val_wa      = free_head_q[SlotWidth-1:0];
        end
      end
      ReqGet: begin
        if (idx_live) begin
          value_d = ValueWidth'(val_rd_q);
        end
      end
      ReqFree: begin
        if (idx_live) begin
          val_we      = 1'b1;
          link_we     = 1'b1;
          free_head_d = idx_ext;
        end else begin
          error_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (val_we) begin
        value_mem[val_wa] <= val_wd;
      end
      if (link_we) begin
        link_mem[idx_q] <= free_head_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q  <= '0;
      fresh_mark_q <= '0;
    end else if (cmd_i.exec) begin
      free_head_q  <= free_head_d;
      fresh_mark_q <= fresh_mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      slot_out_q  <= slot_d;
      value_out_q <= value_d;
      error_q     <= error_d;
    end
  end

  assign slot_out_o  = slot_out_q;
  assign value_out_o = value_out_q;
  assign error_o     = error_q;

`ifndef SYNTHESIS
  a_mark_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_mark_q <= MarkFull)
    else $error("watermark beyond capacity");
  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= fresh_mark_q)
    else $error("free head above watermark");
  a_mark_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> fresh_mark_q == $past(fresh_mark_q))
    else $error("watermark moved outside execution");
`endif

endmodule

// ----- hdl/free_list_handle_table.sv -----
// Handle table with a stack-shaped free list over 1024 slots of 32-bit values.
// Pulse start_i while busy_o is low to transfer a request: insert stores
// ref_value_i in a free slot (recently freed first, else the next fresh one)
// and returns its index; get reads the value at slot_index_i (0 at or above
// the watermark); free nulls a slot and pushes it on the free list. Every
// request gives one result, shown for exactly one cycle with done_o high;
// there is no back-pressure, so the receiver must take it then. A new request
// may be accepted in the cycle the previous result is shown, but not while
// busy_o is high: the capture step reads the link and value memories, the
// execute step updates the free list and writes them back. error_o flags an
// insert into a full table and a free of a slot never handed out; double
// frees are not detected. No clearing pass after reset.
module free_list_handle_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  output logic                            done_o,
  input  logic [flht_pkg::ReqWidth-1:0]   req_type_i,
  input  logic [flht_pkg::SlotWidth-1:0]  slot_index_i,
  input  logic [flht_pkg::ValueWidth-1:0] ref_value_i,
  output logic [flht_pkg::SlotWidth-1:0]  slot_out_o,
  output logic [flht_pkg::ValueWidth-1:0] value_out_o,
  output logic                            error_o
);
  import flht_pkg::*;

  flht_cmd_t cmd;

  flht_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  flht_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_type_i   (req_type_i),
    .slot_index_i (slot_index_i),
    .ref_value_i  (ref_value_i),
    .slot_out_o   (slot_out_o),
    .value_out_o  (value_out_o),
    .error_o      (error_o)
  );

endmodule
